/* sv/rpi_pkg.sv */
// Shared constants, types and the anchor colour table of the rainbow palette interpolator.
package rpi_pkg;

  // Field widths.
  localparam int IDX_W  = 12;   // palette index
  localparam int CC_W   = 13;   // colour count register
  localparam int CH_W   = 8;    // one colour channel
  localparam int LEN_W  = 9;    // segment length and offset inside a segment
  localparam int QUOT_W = 8;    // quotient bits of the channel divide
  localparam int PROD_W = LEN_W + CH_W;
  localparam int SEG_W  = 4;    // segment number and anchor sequencer count

  // Anchor layout: eleven anchors, ten segments, nine inner anchors.
  localparam int ANCHORS  = 11;
  localparam int SEGMENTS = ANCHORS - 1;
  localparam int INNER    = ANCHORS - 2;
  localparam int NUM_CH   = 3;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  // Palette size limits and reset value.
  localparam logic [CC_W-1:0] MIN_COLOURS = CC_W'(ANCHORS);
  localparam logic [CC_W-1:0] MAX_COLOURS = CC_W'(4096);
  localparam logic [CC_W-1:0] CC_RESET    = CC_W'(256);

  // Reciprocal of the segment count for floor((n-1)/10) on a 12-bit value.
  localparam int QSTEP_W     = 9;
  localparam int REM_W       = 4;
  localparam int RECIP_SHIFT = 15;
  localparam logic [IDX_W-1:0] RECIP_SEG =
    IDX_W'((2**RECIP_SHIFT + SEGMENTS - 1) / SEGMENTS);

  // Register loads from an accepted word to the result strobe: two front
  // stages, the queue, the product stage, one stage per quotient bit and
  // the output register.
  localparam int LATENCY = QUOT_W + 5;

  // Anchor colours, one row per channel.
  localparam logic [CH_W-1:0] ANCH_TAB [0:NUM_CH-1][0:ANCHORS-1] = '{
    '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd111, 8'd238, 8'd255},
    '{8'd0,   8'd40,  8'd80,  8'd120, 8'd162, 8'd255, 8'd255, 8'd0,   8'd0,   8'd130, 8'd255},
    '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd238, 8'd255}
  };

  // Classified word handed from the front to the back.
  typedef struct packed {
    logic             in_range;
    logic [SEG_W-1:0] seg;
    logic [LEN_W-1:0] offs;
    logic [LEN_W-1:0] len;
  } item_t;

endpackage

/* sv/rpi_front.sv */
// Front end: colour count register, anchor position sequencer and index classification.
module rpi_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [rpi_pkg::IDX_W-1:0]  in_palette_index,
  input  logic                       cfg_we,
  input  logic [rpi_pkg::CC_W-1:0]   cfg_wdata,
  output logic                       item_valid,
  output rpi_pkg::item_t             item
);

  typedef enum logic [1:0] {ST_IDLE, ST_SETUP, ST_STEP} state_t;

  state_t                             state_r, state_nxt;
  logic                               busy_r, busy_nxt;
  logic [rpi_pkg::CC_W-1:0]           colour_count_r, colour_count_nxt;
  logic [rpi_pkg::IDX_W-1:0]          nm1_r, nm1_nxt;
  logic [rpi_pkg::QSTEP_W-1:0]        qstep_r, qstep_nxt;
  logic [rpi_pkg::REM_W-1:0]          rstep_r, rstep_nxt;
  logic [rpi_pkg::IDX_W-1:0]          yq_r, yq_nxt;
  logic [rpi_pkg::REM_W-1:0]          yr_r, yr_nxt;
  logic [rpi_pkg::SEG_W-1:0]          step_r, step_nxt;
  logic [rpi_pkg::IDX_W-1:0]          anch_r [1:rpi_pkg::INNER];

  logic [rpi_pkg::CC_W-1:0]           n_eff;
  logic [rpi_pkg::IDX_W-1:0]          nm1_calc;
  logic [2*rpi_pkg::IDX_W-1:0]        recip_prod;
  logic [rpi_pkg::QSTEP_W-1:0]        q_div;
  logic [rpi_pkg::REM_W-1:0]          r_div;
  logic [rpi_pkg::REM_W:0]            yr_sum;
  logic                               carry;

  logic                               in_fire;
  logic [rpi_pkg::SEG_W-1:0]          seg_cnt;
  logic                               v1_r;
  logic [rpi_pkg::IDX_W-1:0]          idx1_r;
  logic [rpi_pkg::SEG_W-1:0]          seg1_r;
  logic                               inr1_r;
  logic [rpi_pkg::IDX_W-1:0]          ypos [0:rpi_pkg::ANCHORS-1];
  logic [rpi_pkg::IDX_W-1:0]          y0, y1;
  logic                               v2_r;
  rpi_pkg::item_t                     item2_r, item2_nxt;

  assign in_fire = start && !busy_r;

  // Effective size, then (n-1) split into quotient and remainder by ten.
  always_comb begin
    n_eff = colour_count_r;
    if (colour_count_r < rpi_pkg::MIN_COLOURS) begin
      n_eff = rpi_pkg::MIN_COLOURS;
    end else if (colour_count_r > rpi_pkg::MAX_COLOURS) begin
      n_eff = rpi_pkg::MAX_COLOURS;
    end
    nm1_calc   = rpi_pkg::IDX_W'(n_eff - rpi_pkg::CC_W'(1));
    recip_prod = (2*rpi_pkg::IDX_W)'(nm1_calc) * (2*rpi_pkg::IDX_W)'(rpi_pkg::RECIP_SEG);
    q_div      = recip_prod[rpi_pkg::RECIP_SHIFT +: rpi_pkg::QSTEP_W];
    r_div      = rpi_pkg::REM_W'(nm1_calc - (rpi_pkg::IDX_W'(q_div) << 3)
                                          - (rpi_pkg::IDX_W'(q_div) << 1));
  end

  // One anchor per step: y += q, with the remainder carried in tenths.
  always_comb begin
    yr_sum = {1'b0, yr_r} + {1'b0, rstep_r};
    carry  = yr_sum >= (rpi_pkg::REM_W+1)'(rpi_pkg::SEGMENTS);
    yr_nxt = carry ? rpi_pkg::REM_W'(yr_sum - (rpi_pkg::REM_W+1)'(rpi_pkg::SEGMENTS))
                   : rpi_pkg::REM_W'(yr_sum);
    yq_nxt = yq_r + rpi_pkg::IDX_W'(qstep_r) + rpi_pkg::IDX_W'(carry);
  end

  always_comb begin
    state_nxt        = state_r;
    busy_nxt         = busy_r;
    colour_count_nxt = colour_count_r;
    nm1_nxt          = nm1_r;
    qstep_nxt        = qstep_r;
    rstep_nxt        = rstep_r;
    step_nxt         = step_r;
    case (state_r)
      ST_IDLE: begin
      end
      ST_SETUP: begin
        nm1_nxt   = nm1_calc;
        qstep_nxt = q_div;
        rstep_nxt = r_div;
        step_nxt  = '0;
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        step_nxt = step_r + rpi_pkg::SEG_W'(1);
        if (step_r == rpi_pkg::SEG_W'(rpi_pkg::INNER - 1)) begin
          state_nxt = ST_IDLE;
          busy_nxt  = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_SETUP;
        busy_nxt  = 1'b1;
      end
    endcase
    if (cfg_we) begin
      colour_count_nxt = cfg_wdata;
      state_nxt        = ST_SETUP;
      busy_nxt         = 1'b1;
    end
  end

  // Segment number is the count of inner anchors strictly below the index.
  always_comb begin
    seg_cnt = '0;
    for (int k = 1; k <= rpi_pkg::INNER; k++) begin
      seg_cnt = seg_cnt + rpi_pkg::SEG_W'(anch_r[k] < in_palette_index);
    end
  end

  always_comb begin
    ypos[0] = '0;
    for (int k = 1; k <= rpi_pkg::INNER; k++) begin
      ypos[k] = anch_r[k];
    end
    ypos[rpi_pkg::ANCHORS-1] = nm1_r;
    y0 = ypos[seg1_r];
    y1 = ypos[seg1_r + rpi_pkg::SEG_W'(1)];
    item2_nxt.in_range = inr1_r;
    item2_nxt.seg      = seg1_r;
    item2_nxt.len      = rpi_pkg::LEN_W'(y1 - y0);
    item2_nxt.offs     = rpi_pkg::LEN_W'(idx1_r - y0);
  end

  always_ff @(posedge clk) begin
    nm1_r   <= nm1_nxt;
    qstep_r <= qstep_nxt;
    rstep_r <= rstep_nxt;
    if (state_r == ST_STEP) begin
      yq_r <= yq_nxt;
      yr_r <= yr_nxt;
      for (int k = 1; k < rpi_pkg::INNER; k++) begin
        anch_r[k] <= anch_r[k+1];
      end
      anch_r[rpi_pkg::INNER] <= yq_nxt;
    end else begin
      yq_r <= '0;
      yr_r <= '0;
    end
    idx1_r  <= in_palette_index;
    seg1_r  <= seg_cnt;
    inr1_r  <= in_palette_index <= nm1_r;
    item2_r <= item2_nxt;
    if (!rst_n) begin
      state_r        <= ST_SETUP;
      busy_r         <= 1'b1;
      colour_count_r <= rpi_pkg::CC_RESET;
      step_r         <= '0;
      v1_r           <= 1'b0;
      v2_r           <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      busy_r         <= busy_nxt;
      colour_count_r <= colour_count_nxt;
      step_r         <= step_nxt;
      v1_r           <= in_fire;
      v2_r           <= v1_r;
    end
  end

  assign busy       = busy_r;
  assign item_valid = v2_r;
  assign item       = item2_r;

`ifndef ASSERT_OFF
  a_cfg_rebuilds: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> busy_r)
    else $error("register write did not start an anchor rebuild");

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> !v1_r)
    else $error("word entered the front end during an anchor rebuild");
`endif

endmodule

/* sv/rpi_queue.sv */
// Two-entry queue that decouples the classifying front end from the arithmetic back end.
module rpi_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rpi_pkg::item_t push_item,
  output logic           pop,
  output rpi_pkg::item_t pop_item
);

  rpi_pkg::item_t slot_r [0:1];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     count_r, count_nxt;
  logic           wr_en;

  // The back end never stalls, so any held word leaves in the next cycle.
  assign pop      = count_r != 2'd0;
  assign pop_item = slot_r[rd_ptr_r];
  assign wr_en    = push && (count_r != 2'd2 || pop);

  always_comb begin
    count_nxt = count_r + 2'(wr_en) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= push_item;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_queue_shallow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'd1)
    else $error("queue holds more than one word while the back end drains it");
`endif

endmodule

/* sv/rpi_back.sv */
// Back end: per-channel product, pipelined restoring divide and final colour assembly.
module rpi_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      item_valid,
  input  rpi_pkg::item_t            item,
  output logic                      out_valid,
  output logic [rpi_pkg::CH_W-1:0]  out_red,
  output logic [rpi_pkg::CH_W-1:0]  out_green,
  output logic [rpi_pkg::CH_W-1:0]  out_blue,
  output logic                      out_index_in_range
);

  typedef struct packed {
    logic                                              valid;
    logic                                              in_range;
    logic [rpi_pkg::LEN_W-1:0]                         len;
    logic [rpi_pkg::NUM_CH-1:0][rpi_pkg::PROD_W-1:0]   rem;
    logic [rpi_pkg::NUM_CH-1:0][rpi_pkg::QUOT_W-1:0]   quo;
    logic [rpi_pkg::NUM_CH-1:0]                        neg;
    logic [rpi_pkg::NUM_CH-1:0][rpi_pkg::CH_W-1:0]     base;
  } div_stage_t;

  div_stage_t                                      pipe_r   [0:rpi_pkg::QUOT_W];
  div_stage_t                                      pipe_nxt [0:rpi_pkg::QUOT_W];
  logic [rpi_pkg::NUM_CH-1:0][rpi_pkg::CH_W-1:0]   rgb_nxt;
  logic [rpi_pkg::NUM_CH-1:0][rpi_pkg::CH_W-1:0]   rgb_r;
  logic                                            out_valid_r;
  logic                                            inr_r;

  // Entry: colour step between the two anchors times the offset, as sign and magnitude.
  // Then one quotient bit per stage, most significant first. The magnitude is
  // below 256 times the segment length, so eight bits cover the quotient.
  always_comb begin
    logic [rpi_pkg::CH_W-1:0]   a0, a1, mag;
    logic [rpi_pkg::PROD_W-1:0] dsh;
    pipe_nxt[0].valid    = item_valid;
    pipe_nxt[0].in_range = item.in_range;
    pipe_nxt[0].len      = item.len;
    pipe_nxt[0].quo      = '0;
    for (int c = 0; c < rpi_pkg::NUM_CH; c++) begin
      a0 = rpi_pkg::ANCH_TAB[c][item.seg];
      a1 = rpi_pkg::ANCH_TAB[c][item.seg + rpi_pkg::SEG_W'(1)];
      pipe_nxt[0].neg[c]  = a1 < a0;
      mag                 = (a1 < a0) ? a0 - a1 : a1 - a0;
      pipe_nxt[0].rem[c]  = rpi_pkg::PROD_W'(mag) * rpi_pkg::PROD_W'(item.offs);
      pipe_nxt[0].base[c] = a0;
    end
    for (int s = 0; s < rpi_pkg::QUOT_W; s++) begin
      pipe_nxt[s+1] = pipe_r[s];
      dsh = rpi_pkg::PROD_W'(pipe_r[s].len) << (rpi_pkg::QUOT_W - 1 - s);
      for (int c = 0; c < rpi_pkg::NUM_CH; c++) begin
        if (pipe_r[s].rem[c] >= dsh) begin
          pipe_nxt[s+1].rem[c] = pipe_r[s].rem[c] - dsh;
          pipe_nxt[s+1].quo[c][rpi_pkg::QUOT_W - 1 - s] = 1'b1;
        end
      end
    end
    // Synchronous reset empties every stage.
    if (!rst_n) begin
      for (int s = 0; s <= rpi_pkg::QUOT_W; s++) begin
        pipe_nxt[s].valid = 1'b0;
      end
    end
  end

  // Truncation toward zero: apply the sign to the unsigned quotient; an index beyond the palette gives zero.
  always_comb begin
    logic [rpi_pkg::CH_W-1:0] q;
    for (int c = 0; c < rpi_pkg::NUM_CH; c++) begin
      q = rpi_pkg::CH_W'(pipe_r[rpi_pkg::QUOT_W].quo[c]);
      if (!pipe_r[rpi_pkg::QUOT_W].in_range) begin
        rgb_nxt[c] = '0;
      end else if (pipe_r[rpi_pkg::QUOT_W].neg[c]) begin
        rgb_nxt[c] = pipe_r[rpi_pkg::QUOT_W].base[c] - q;
      end else begin
        rgb_nxt[c] = pipe_r[rpi_pkg::QUOT_W].base[c] + q;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s <= rpi_pkg::QUOT_W; s++) begin
      pipe_r[s] <= pipe_nxt[s];
    end
    rgb_r <= rgb_nxt;
    inr_r <= pipe_r[rpi_pkg::QUOT_W].in_range;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= pipe_r[rpi_pkg::QUOT_W].valid;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_red            = rgb_r[rpi_pkg::CH_RED];
  assign out_green          = rgb_r[rpi_pkg::CH_GREEN];
  assign out_blue           = rgb_r[rpi_pkg::CH_BLUE];
  assign out_index_in_range = inr_r;

endmodule

/* sv/rainbow_palette_interpolator_core.sv */
// Top level of the rainbow palette interpolator: front end, queue and back end.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | start / busy       | in_palette_index[11:0]
//  result   | out_valid (strobe) | out_red, out_green, out_blue [7:0],
//           |                    | out_index_in_range
//  config   | cfg_we             | cfg_wdata[12:0] (colour_count)
//
// A word is taken at every clock edge with start high and busy low, one per
// cycle. Its result appears on out_valid once it has passed through two front
// stages, the queue, the product stage, eight divide stages and the output
// register. Reset is synchronous and active low. After reset and after each
// configuration write, busy stays high while the anchor sequencer rebuilds
// the nine inner anchor positions one per cycle. The receiver cannot stall:
// each result is shown for one cycle only.
module rainbow_palette_interpolator_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [rpi_pkg::IDX_W-1:0] in_palette_index,
  input  logic                      cfg_we,
  input  logic [rpi_pkg::CC_W-1:0]  cfg_wdata,
  output logic                      out_valid,
  output logic [rpi_pkg::CH_W-1:0]  out_red,
  output logic [rpi_pkg::CH_W-1:0]  out_green,
  output logic [rpi_pkg::CH_W-1:0]  out_blue,
  output logic                      out_index_in_range
);

  logic           front_valid;
  rpi_pkg::item_t front_item;
  logic           back_valid;
  rpi_pkg::item_t back_item;

  // The front end owns the register and the anchor positions; it finds the
  // segment around the index and hands over the segment number, the
  // segment length and the offset of the index inside it.
  rpi_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_palette_index (in_palette_index),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .item_valid       (front_valid),
    .item             (front_item)
  );

  rpi_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_valid),
    .push_item (front_item),
    .pop       (back_valid),
    .pop_item  (back_item)
  );

  // The back end interpolates all three channels in parallel lanes and
  // forces black for an index beyond the palette.
  rpi_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .item_valid         (back_valid),
    .item               (back_item),
    .out_valid          (out_valid),
    .out_red            (out_red),
    .out_green          (out_green),
    .out_blue           (out_blue),
    .out_index_in_range (out_index_in_range)
  );

`ifndef ASSERT_OFF
  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, rpi_pkg::LATENCY))
    else $error("result word without an accepted word one latency earlier");

  a_black_outside: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_index_in_range) |->
      (out_red == '0 && out_green == '0 && out_blue == '0))
    else $error("index beyond the palette did not give black");
`endif

endmodule

/* sim/rpi_colour_checker.sv */
`timescale 1ns / 1ps
// Checker of the rainbow palette interpolator: predicts each colour and compares the results.
module rpi_colour_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic [rpi_pkg::IDX_W-1:0] in_palette_index,
  input  logic                      cfg_we,
  input  logic [rpi_pkg::CC_W-1:0]  cfg_wdata,
  input  logic                      out_valid,
  input  logic [rpi_pkg::CH_W-1:0]  out_red,
  input  logic [rpi_pkg::CH_W-1:0]  out_green,
  input  logic [rpi_pkg::CH_W-1:0]  out_blue,
  input  logic                      out_index_in_range,
  output int                        mismatches,
  output int                        pending
);

  typedef struct packed {
    logic [rpi_pkg::CH_W-1:0] red;
    logic [rpi_pkg::CH_W-1:0] green;
    logic [rpi_pkg::CH_W-1:0] blue;
    logic                     in_range;
  } colour_t;

  // Anchor colours from red through the oranges, yellow, green, blue, violet to white.
  localparam int RED_AT   [0:10] = '{255, 255, 255, 255, 255, 255, 0, 0, 111, 238, 255};
  localparam int GREEN_AT [0:10] = '{0, 40, 80, 120, 162, 255, 255, 0, 0, 130, 255};
  localparam int BLUE_AT  [0:10] = '{0, 0, 0, 0, 0, 0, 0, 255, 255, 238, 255};

  logic [rpi_pkg::CC_W-1:0] palette_size;
  colour_t                  expected_colours [$];
  colour_t                  want;

  function automatic int anchor_at(int n, int j);
    return ((n - 1) * j) / 10;
  endfunction

  // Signed division in SystemVerilog truncates toward zero, as the block does.
  function automatic logic [rpi_pkg::CH_W-1:0] blend(int lo, int hi, int i, int y0, int y1);
    int c;
    c = lo + ((hi - lo) * (i - y0)) / (y1 - y0);
    return c[rpi_pkg::CH_W-1:0];
  endfunction

  function automatic colour_t predict_colour(logic [rpi_pkg::IDX_W-1:0] idx,
                                             logic [rpi_pkg::CC_W-1:0]  count);
    int      n;
    int      i;
    int      seg;
    int      y0;
    int      y1;
    colour_t c;
    n = int'(count);
    if (n < 11) n = 11;
    if (n > 4096) n = 4096;
    i = int'(idx);
    c = '0;
    if (i >= n) return c;
    seg = 0;
    while (seg < 9 && anchor_at(n, seg + 1) < i) seg++;
    y0 = anchor_at(n, seg);
    y1 = anchor_at(n, seg + 1);
    c.red      = blend(RED_AT[seg], RED_AT[seg + 1], i, y0, y1);
    c.green    = blend(GREEN_AT[seg], GREEN_AT[seg + 1], i, y0, y1);
    c.blue     = blend(BLUE_AT[seg], BLUE_AT[seg + 1], i, y0, y1);
    c.in_range = 1'b1;
    return c;
  endfunction

  task automatic report_mismatch(string what, int got, int exp_val);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, exp_val);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      palette_size = rpi_pkg::CC_RESET;
      mismatches   = 0;
      expected_colours.delete();
    end else begin
      if (cfg_we) palette_size = cfg_wdata;
      if (start && !busy)
        expected_colours.push_back(predict_colour(in_palette_index, palette_size));
      if (out_valid) begin
        if (expected_colours.size() == 0) begin
          report_mismatch("result word with none outstanding, red", int'(out_red), 0);
        end else begin
          want = expected_colours.pop_front();
          if (out_red !== want.red)
            report_mismatch("red", int'(out_red), int'(want.red));
          if (out_green !== want.green)
            report_mismatch("green", int'(out_green), int'(want.green));
          if (out_blue !== want.blue)
            report_mismatch("blue", int'(out_blue), int'(want.blue));
          if (out_index_in_range !== want.in_range)
            report_mismatch("index_in_range", int'(out_index_in_range), int'(want.in_range));
        end
      end
    end
    pending <= expected_colours.size();
  end

endmodule

/* sim/rainbow_palette_interpolator_core_tb.sv */
`timescale 1ns / 1ps
// Testbench top of the rainbow palette interpolator: stimulus, watchdog and verdict.
module rainbow_palette_interpolator_core_tb;

  // Cycles with no word accepted on either side before the run is declared hung.
  // The longest honest quiet spell is the anchor rebuild after a write, a short
  // sender gap and the pipeline, so this is ample.
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_WORDS = 900;
  localparam int PHASES       = 12;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [rpi_pkg::IDX_W-1:0] in_palette_index;
  logic                      cfg_we;
  logic [rpi_pkg::CC_W-1:0]  cfg_wdata;
  logic                      out_valid;
  logic [rpi_pkg::CH_W-1:0]  out_red;
  logic [rpi_pkg::CH_W-1:0]  out_green;
  logic [rpi_pkg::CH_W-1:0]  out_blue;
  logic                      out_index_in_range;

  int mismatches;
  int pending;
  int stall_cycles;
  int words_sent;

  // The stimulus keeps its own note of the palette size only to aim indexes
  // at the interesting places; the checker does all of the predicting.
  logic [rpi_pkg::CC_W-1:0] colour_count;

  rainbow_palette_interpolator_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_palette_index  (in_palette_index),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_index_in_range(out_index_in_range)
  );

  rpi_colour_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_palette_index  (in_palette_index),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_index_in_range(out_index_in_range),
    .mismatches        (mismatches),
    .pending           (pending)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // The watchdog restarts whenever a word moves on either channel. Reset and the
  // anchor rebuild are short enough that they never come near the limit.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("rainbow_palette_interpolator_core_tb NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Effective palette size: small counts act as eleven, large ones saturate.
  function automatic int palette_entries(logic [rpi_pkg::CC_W-1:0] count);
    int n;
    n = int'(count);
    if (n < 11) n = 11;
    if (n > 4096) n = 4096;
    return n;
  endfunction

  // Most indexes fall inside the palette, a good share right on or beside an
  // anchor where the segment choice flips, and the rest probe the upper edge
  // or wander over the whole index range to exercise the out-of-range path.
  function automatic logic [rpi_pkg::IDX_W-1:0] pick_index(int n);
    int roll;
    int spot;
    roll = $urandom_range(99);
    if (roll < 65) begin
      spot = $urandom_range(n - 1);
    end else if (roll < 82) begin
      spot = ((n - 1) * $urandom_range(10)) / 10 + $urandom_range(2) - 1;
    end else if (roll < 92) begin
      spot = $urandom_range(4095);
    end else begin
      spot = n - 1 + $urandom_range(1);
    end
    if (spot < 0) spot = 0;
    if (spot > 4095) spot = 4095;
    return spot[rpi_pkg::IDX_W-1:0];
  endfunction

  // The sender pauses in about eleven words of a hundred, except through one
  // long stretch in the middle of the run where it keeps start high throughout.
  function automatic bit sender_pauses();
    if (words_sent >= 380 && words_sent < 600) return 1'b0;
    return $urandom_range(99) < 11;
  endfunction

  // Offer one word and hold it until the block takes it. While paused the
  // index bus carries junk, which the block must ignore with start low.
  task automatic send_index(logic [rpi_pkg::IDX_W-1:0] idx);
    start            <= 1'b1;
    in_palette_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
    if (sender_pauses()) begin
      start            <= 1'b0;
      in_palette_index <= rpi_pkg::IDX_W'($urandom);
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // The palette size is only changed with the pipeline drained. Every word
  // yields a result, so an empty scoreboard means the block is idle.
  task automatic write_colour_count(logic [rpi_pkg::CC_W-1:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_we       <= 1'b1;
    cfg_wdata    <= value;
    colour_count  = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [rpi_pkg::CC_W-1:0] phase_counts [0:8];
    int                       n;
    phase_counts = '{13'd4096, 13'd8191, 13'd11, 13'd5, 13'd1,
                     13'd4095, 13'd4097, 13'd1000, 13'd12};
    rst_n            = 1'b0;
    start            = 1'b0;
    in_palette_index = '0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    colour_count     = rpi_pkg::CC_RESET;
    words_sent       = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset palette of 256 entries: both ends, the first segment boundary,
    // the middle, an index far past the end, the last entry, the first index
    // past the end and the top index.
    send_index(12'd0);
    send_index(12'd1);
    send_index(12'd25);
    send_index(12'd26);
    send_index(12'd127);
    send_index(12'd128);
    send_index(12'd2048);
    send_index(12'd254);
    send_index(12'd255);
    send_index(12'd256);
    send_index(12'd4095);

    // A count of zero acts as the smallest palette of eleven, where every
    // entry is an anchor colour; index eleven is just out of range.
    write_colour_count('0);
    for (int i = 0; i <= 11; i++) send_index(i[rpi_pkg::IDX_W-1:0]);

    // Random phases: the full and saturated palettes, the small ones, odd
    // sizes around the limits, then random sizes over the whole register.
    for (int p = 0; p < PHASES; p++) begin
      if (p < 9) write_colour_count(phase_counts[p]);
      else write_colour_count(rpi_pkg::CC_W'($urandom_range(8191)));
      n = palette_entries(colour_count);
      repeat (RANDOM_WORDS / PHASES) send_index(pick_index(n));
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (rpi_pkg::LATENCY + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("rainbow_palette_interpolator_core_tb OK");
    end else begin
      $display("rainbow_palette_interpolator_core_tb NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/rpi_pkg.sv
sv/rpi_front.sv
sv/rpi_queue.sv
sv/rpi_back.sv
sv/rainbow_palette_interpolator_core.sv
sim/rpi_colour_checker.sv
sim/rainbow_palette_interpolator_core_tb.sv
